@@ sv/bps_pkg.sv @@
`default_nettype none
package bps_pkg;
  localparam int unsigned MaxCols  = 128;
  localparam int unsigned MaxRows  = 128;
  localparam int unsigned FracBits = 8;
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned BankAw   = ColW + RowW - 2;
  localparam int unsigned CoordW   = 15;
  localparam int unsigned WtW      = 2 * FracBits + 1;
  localparam logic [7:0]  ChanMax  = 8'hFF;

  localparam logic [0:0] OpWrite  = 1'b0;
  localparam logic [0:0] OpSample = 1'b1;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic [FracBits:0] u;
    logic [FracBits:0] v;
    logic              sel_c;
    logic              sel_r;
    logic              has_r;
    logic              has_d;
    logic              flag;
  } smp_ctl_t;
endpackage
`default_nettype wire

@@ sv/bilinear_pixel_sampler.sv @@
// a sample result passes the bank read register, then the weight multiply register,
//   then rounding and packing into the output register
// throughput: one item per cycle, write or sample, while the output is not stalled;
//   four parity banks serve the four neighbour reads of a sample together
// reset: control clears at once, image size returns to 128 by 128; pixel store
//   contents stay undefined until written
`default_nettype none
module bilinear_pixel_sampler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [6:0]  write_col_i,
  input  wire logic [6:0]  write_row_i,
  input  wire logic [23:0] write_rgb_i,
  input  wire logic [14:0] sample_x_i,
  input  wire logic [14:0] sample_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      sampled_rgb_o,
  output logic             out_of_range_o
);
  localparam int unsigned Fb = bps_pkg::FracBits;
  localparam int unsigned Cw = bps_pkg::ColW;
  localparam int unsigned Rw = bps_pkg::RowW;
  localparam int unsigned Aw = bps_pkg::BankAw;
  localparam int unsigned Ww = bps_pkg::WtW;

  // configuration registers
  logic [7:0] width_q, height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd128;
      height_q <= 8'd128;
    end else if (cfg_we_i) begin
      if (cfg_index_i == bps_pkg::RegWidth) width_q <= cfg_data_i;
      else                                  height_q <= cfg_data_i;
    end
  end

  // effective dimensions, zero acts as one, saturated at store size
  logic [Cw:0] w_eff;
  logic [Rw:0] h_eff;
  always_comb begin
    if (width_q == 8'd0) w_eff = (Cw+1)'(1);
    else if ({1'b0, width_q} > 9'(bps_pkg::MaxCols)) w_eff = (Cw+1)'(bps_pkg::MaxCols);
    else w_eff = (Cw+1)'(width_q);
    if (height_q == 8'd0) h_eff = (Rw+1)'(1);
    else if ({1'b0, height_q} > 9'(bps_pkg::MaxRows)) h_eff = (Rw+1)'(bps_pkg::MaxRows);
    else h_eff = (Rw+1)'(height_q);
  end

  // pipeline flow: stage 1 (read), stage 2 (multiply), output register
  logic s1_v_q, s2_v_q, out_v_q;
  logic adv_out, adv2, adv1;
  assign adv_out    = !out_v_q || out_ready_i;
  assign adv2       = adv_out;
  assign adv1       = adv2;
  assign in_ready_o = adv1;

  logic acc_in, is_smp;
  assign acc_in = in_valid_i && in_ready_o;
  assign is_smp = op_i == bps_pkg::OpSample;

  // coordinate split with edge clamp, compared at full edge width
  logic [Cw+Fb:0] ex;
  logic [Rw+Fb:0] ey;
  logic [Cw+Fb:0] cx;
  logic [Rw+Fb:0] cy;
  logic           fx, fy;
  logic [Cw:0]    j_w;
  logic [Rw:0]    i_w;
  logic [Cw-1:0]  j;
  logic [Rw-1:0]  i;
  logic [Fb-1:0]  u, v;
  logic           has_r, has_d;
  always_comb begin
    ex = {w_eff, Fb'(0)};
    ey = {h_eff, Fb'(0)};
    fx = ex < (Cw+Fb+1)'(sample_x_i);
    fy = ey < (Rw+Fb+1)'(sample_y_i);
    cx = fx ? ex : (Cw+Fb+1)'(sample_x_i);
    cy = fy ? ey : (Rw+Fb+1)'(sample_y_i);
    j_w = (Cw+1)'(cx >> Fb);
    i_w = (Rw+1)'(cy >> Fb);
    u = cx[Fb-1:0];
    v = cy[Fb-1:0];
    if (j_w >= w_eff) begin
      j_w = w_eff - (Cw+1)'(1);
      u = '0;
    end
    if (i_w >= h_eff) begin
      i_w = h_eff - (Rw+1)'(1);
      v = '0;
    end
    j = j_w[Cw-1:0];
    i = i_w[Rw-1:0];
    has_r = (j_w + (Cw+1)'(1)) < w_eff;
    has_d = (i_w + (Rw+1)'(1)) < h_eff;
  end

  // bank addressing: bank index = {row parity, column parity}
  logic [Cw-1:0] j1;
  logic [Rw-1:0] i1;
  logic [Cw-2:0] ce, co;
  logic [Rw-2:0] re, ro;
  always_comb begin
    j1 = j + Cw'(1);
    i1 = i + Rw'(1);
    ce = j[0] ? j1[Cw-1:1] : j[Cw-1:1];
    co = j[Cw-1:1];
    re = i[0] ? i1[Rw-1:1] : i[Rw-1:1];
    ro = i[Rw-1:1];
  end

  logic [Aw-1:0] raddr [4];
  logic [23:0]   rdata [4];
  logic          bwe   [4];
  logic [Aw-1:0] waddr;
  assign waddr = {write_row_i[Rw-1:1], write_col_i[Cw-1:1]};
  assign raddr[0] = {re, ce};
  assign raddr[1] = {re, co};
  assign raddr[2] = {ro, ce};
  assign raddr[3] = {ro, co};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign bwe[b] = acc_in && !is_smp && ({write_row_i[0], write_col_i[0]} == 2'(b));
    bps_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (bwe[b]),
      .waddr_i (waddr),
      .wdata_i (write_rgb_i),
      .re_i    (adv1),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  // a write in the same cycle as a read of that entry lands after the
  // read, matching item order

  bps_pkg::smp_ctl_t s1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv1) s1_v_q <= acc_in && is_smp;
  end
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q.u     <= (Fb+1)'(u);
      s1_q.v     <= (Fb+1)'(v);
      s1_q.sel_c <= j[0];
      s1_q.sel_r <= i[0];
      s1_q.has_r <= has_r;
      s1_q.has_d <= has_d;
      s1_q.flag  <= fx || fy;
    end
  end

  // stage 1 to 2: route banks to neighbours, weight each channel
  logic [23:0] px [4];
  logic [1:0]  bsel [4];
  logic [Fb:0] one, nu, nv;
  logic [Ww-1:0] wt [4];
  always_comb begin
    bsel[0] = {s1_q.sel_r, s1_q.sel_c};
    bsel[1] = {s1_q.sel_r, !s1_q.sel_c};
    bsel[2] = {!s1_q.sel_r, s1_q.sel_c};
    bsel[3] = {!s1_q.sel_r, !s1_q.sel_c};
    px[0] = rdata[bsel[0]];
    px[1] = s1_q.has_r ? rdata[bsel[1]] : px[0];
    px[2] = s1_q.has_d ? rdata[bsel[2]] : px[0];
    px[3] = (s1_q.has_r && s1_q.has_d) ? rdata[bsel[3]] : px[0];
    one = (Fb+1)'(1) << Fb;
    nu = one - s1_q.u;
    nv = one - s1_q.v;
    wt[0] = Ww'(nu) * Ww'(nv);
    wt[1] = Ww'(s1_q.u) * Ww'(nv);
    wt[2] = Ww'(nu) * Ww'(s1_q.v);
    wt[3] = Ww'(s1_q.u) * Ww'(s1_q.v);
  end

  logic [Ww+7:0] prod_q [4][3];
  logic          flag2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv2) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      flag2_q <= s1_q.flag;
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[k][c] <= (Ww+8)'(px[k][c*8 +: 8]) * (Ww+8)'(wt[k]);
        end
      end
    end
  end

  // sum, round half up, saturate
  logic [Ww+9:0] acc [3];
  logic [23:0]   rgb_d;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = (Ww+10)'(prod_q[0][c]) + (Ww+10)'(prod_q[1][c])
             + (Ww+10)'(prod_q[2][c]) + (Ww+10)'(prod_q[3][c])
             + ((Ww+10)'(1) << (2*Fb-1));
      acc[c] = acc[c] >> (2*Fb);
      rgb_d[c*8 +: 8] = (acc[c] > (Ww+10)'(bps_pkg::ChanMax)) ? bps_pkg::ChanMax
                                                              : acc[c][7:0];
    end
  end

  logic [23:0] rgb_q;
  logic        oor_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv_out) out_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      rgb_q <= rgb_d;
      oor_q <= flag2_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign sampled_rgb_o  = rgb_q;
  assign out_of_range_o = oor_q;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(rgb_q))
    else $error("result changed under stall");
  // accepted sample reaches stage 1
  a_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && is_smp |=> s1_v_q)
    else $error("sample lost at stage 1");
  // writes make no result
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && !is_smp |=> !s1_v_q)
    else $error("write produced a result");
endmodule
`default_nettype wire

@@ sv/bps_bank.sv @@
`default_nettype none
// one parity bank of the pixel store, one write and one read port
module bps_bank (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [bps_pkg::BankAw-1:0] waddr_i,
  input  wire logic [23:0]                wdata_i,
  input  wire logic                       re_i,
  input  wire logic [bps_pkg::BankAw-1:0] raddr_i,
  output logic      [23:0]                rdata_o
);
  logic [23:0] mem_q [2**bps_pkg::BankAw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire
